### src/upi_pkg.sv
// Shared constants and the CORDIC arctangent table for the unicycle pose integrator.
package upi_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ANGLE_BITS   = 16;
	localparam int TAB_LEN      = 24;
	localparam int TAB_IDX_W    = $clog2(TAB_LEN);
	localparam int ITER_W       = $clog2(CORDIC_STEPS);

	// CORDIC datapath widths: x/y are Q2.30 with headroom, z is a 32-bit binary angle plus sign
	localparam int XY_W   = 34;
	localparam int Z_W    = 33;
	localparam int TRIG_W = 16;

	// Q2.30 start value, the inverse of the CORDIC gain
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// Default integration interval, about 0.1 s in Q0.16
	localparam logic [15:0] TIME_STEP_RST = 16'd6554;

	// Position reset, 1.0 m in Q16.16
	localparam logic signed [31:0] POS_RST = 32'sd65536;

	// atan(2^-i) in 32-bit binary angle units
	function automatic logic [31:0] atan_angle(input logic [TAB_IDX_W-1:0] idx);
		logic [31:0] val;
		case (idx)
			5'd0:    val = 32'h20000000;
			5'd1:    val = 32'h12E4051D;
			5'd2:    val = 32'h09FB385B;
			5'd3:    val = 32'h051111D4;
			5'd4:    val = 32'h028B0D43;
			5'd5:    val = 32'h0145D7E1;
			5'd6:    val = 32'h00A2F61E;
			5'd7:    val = 32'h00517C55;
			5'd8:    val = 32'h0028BE53;
			5'd9:    val = 32'h00145F2E;
			5'd10:   val = 32'h000A2F98;
			5'd11:   val = 32'h000517CC;
			5'd12:   val = 32'h00028BE6;
			5'd13:   val = 32'h000145F3;
			5'd14:   val = 32'h0000A2F9;
			5'd15:   val = 32'h0000517C;
			5'd16:   val = 32'h000028BE;
			5'd17:   val = 32'h0000145F;
			5'd18:   val = 32'h00000A2F;
			5'd19:   val = 32'h00000517;
			5'd20:   val = 32'h0000028B;
			5'd21:   val = 32'h00000145;
			5'd22:   val = 32'h000000A2;
			5'd23:   val = 32'h00000051;
			default: val = 32'h00000000;
		endcase
		return val;
	endfunction

endpackage

### src/unicycle_pose_integrator.sv
// Top level: command sequencer, shared multiplier and pose state of the unicycle odometry.
//
// Each drive command (forward_speed, turn_rate) advances the heading by turn_rate * time_step,
// evaluates cosine and sine of the new heading with an iterative CORDIC (one micro-rotation
// per cycle), and adds forward_speed * time_step * cos/sin to the saturating Q16.16 X/Y
// position. A command passes through the states HEAD, HUPD, ROT, CORD, MX, MY, ADDY and OUT:
// the CORDIC is loaded, makes its 16 micro-rotations and rounds its outputs, while passes
// through the single shared multiplier serve the heading increment, speed times step, the X
// term and the Y term; these two terms then go into the position through the final
// adds and the hand-off to the output register. in_ready is high only while the block is idle;
// a finished result sits in the output register, so a new command is taken while the previous
// pose still waits for out_ready. If that pose is still waiting when the next result is done,
// the sequencer holds until the output register frees. Pose resets to (1.0 m, 1.0 m,
// heading 0), time_step to 0.1 s; write time_step only while no command is in flight.
module unicycle_pose_integrator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [15:0]                        cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [15:0]                 forward_speed,
	input  logic signed [20:0]                 turn_rate,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [31:0]                 pose_x,
	output logic signed [31:0]                 pose_y,
	output logic [15:0]                        heading,
	output logic signed [15:0]                 linear_speed_echo,
	output logic signed [20:0]                 angular_speed_echo
);

	localparam int AB      = upi_pkg::ANGLE_BITS;
	localparam int HEAD_SH = 32 - AB;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_HEAD = 9'b000000010,
		S_HUPD = 9'b000000100,
		S_ROT  = 9'b000001000,
		S_CORD = 9'b000010000,
		S_MX   = 9'b000100000,
		S_MY   = 9'b001000000,
		S_ADDY = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t                   state_q;
	logic [15:0]              time_step_q;
	logic signed [15:0]       spd_q;
	logic signed [20:0]       rate_q;
	logic signed [31:0]       spdt_q;
	logic signed [49:0]       prod_q;
	logic signed [31:0]       pos_x_q, pos_y_q;
	logic [AB-1:0]            heading_q;
	logic                     out_valid_q;
	logic signed [31:0]       pose_x_q, pose_y_q;
	logic [15:0]              heading_out_q;
	logic signed [15:0]       lin_echo_q;
	logic signed [20:0]       ang_echo_q;

	logic signed [32:0]       mul_a;
	logic signed [16:0]       mul_b;
	logic signed [49:0]       mul_p;
	logic [31:0]              head_rnd;
	logic [31:0]              head_wide;
	logic                     cord_done;
	logic signed [15:0]       cos_val, sin_val;
	logic                     in_fire, out_free;

	function automatic logic signed [31:0] pos_add(
		input logic signed [31:0] p,
		input logic signed [49:0] prod
	);
		logic signed [49:0] rnd;
		logic signed [32:0] sum;
		logic signed [31:0] r;
		rnd = prod + 50'sd4194304;
		sum = 33'(p) + 33'($signed(rnd[49:23]));
		if (sum[32] != sum[31])
			r = sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		else
			r = sum[31:0];
		return r;
	endfunction

	upi_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_ROT),
		.angle   (heading_q),
		.done    (cord_done),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Select operands of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_HEAD: begin
				mul_a = 33'(rate_q);
				mul_b = $signed({1'b0, time_step_q});
			end
			S_HUPD: begin
				mul_a = 33'(spd_q);
				mul_b = $signed({1'b0, time_step_q});
			end
			S_MX: begin
				mul_a = 33'(spdt_q);
				mul_b = 17'(cos_val);
			end
			S_MY: begin
				mul_a = 33'(spdt_q);
				mul_b = 17'(sin_val);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Heading increment: rounded half up, only the low angle bits matter
	assign head_rnd  = prod_q[31:0] + (32'd1 << (HEAD_SH - 1));
	assign head_wide = {heading_q, {HEAD_SH{1'b0}}};

	// Sequencer and pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			time_step_q <= upi_pkg::TIME_STEP_RST;
			pos_x_q     <= upi_pkg::POS_RST;
			pos_y_q     <= upi_pkg::POS_RST;
			heading_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				time_step_q <= cfg_wdata;
			// Raise valid on a new result, drop it once the transaction is taken
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire)
						state_q <= S_HEAD;
				end
				S_HEAD: state_q <= S_HUPD;
				S_HUPD: begin
					heading_q <= heading_q + head_rnd[31:HEAD_SH];
					state_q   <= S_ROT;
				end
				S_ROT:  state_q <= S_CORD;
				S_CORD: begin
					if (cord_done)
						state_q <= S_MX;
				end
				S_MX:   state_q <= S_MY;
				S_MY: begin
					pos_x_q <= pos_add(pos_x_q, prod_q);
					state_q <= S_ADDY;
				end
				S_ADDY: begin
					pos_y_q <= pos_add(pos_y_q, prod_q);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command, product and result registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			spd_q  <= forward_speed;
			rate_q <= turn_rate;
		end
		if (state_q == S_HEAD || state_q == S_MX || state_q == S_MY)
			prod_q <= mul_p;
		if (state_q == S_HUPD)
			spdt_q <= mul_p[31:0];
		if (state_q == S_OUT && out_free) begin
			pose_x_q      <= pos_x_q;
			pose_y_q      <= pos_y_q;
			heading_out_q <= head_wide[31:16];
			lin_echo_q    <= spd_q;
			ang_echo_q    <= rate_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign pose_x             = pose_x_q;
	assign pose_y             = pose_y_q;
	assign heading            = heading_out_q;
	assign linear_speed_echo  = lin_echo_q;
	assign angular_speed_echo = ang_echo_q;

endmodule

### src/upi_cordic.sv
// Iterative CORDIC rotator: one micro-rotation per cycle, cosine and sine rounded to Q1.15.
module upi_cordic (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [upi_pkg::ANGLE_BITS-1:0]       angle,
	output logic                                 done,
	output logic signed [upi_pkg::TRIG_W-1:0]    cos_val,
	output logic signed [upi_pkg::TRIG_W-1:0]    sin_val
);

	localparam int XY_W  = upi_pkg::XY_W;
	localparam int Z_W   = upi_pkg::Z_W;
	localparam int RND_W = XY_W + 1 - 15;

	logic signed [XY_W-1:0]             x_q, y_q;
	logic signed [Z_W-1:0]              z_q;
	logic [upi_pkg::ITER_W-1:0]         iter_q;
	logic                               busy_q, round_q, done_q, neg_q;
	logic signed [upi_pkg::TRIG_W-1:0]  cos_q, sin_q;

	logic [31:0]             a_full, a_rot;
	logic                    fold;
	logic signed [Z_W-1:0]   z_init, step_atan;
	logic signed [XY_W-1:0]  xs, ys, x_nx, y_nx, xn, yn;
	logic signed [XY_W:0]    x_rnd, y_rnd;
	logic                    last_iter;

	function automatic logic signed [upi_pkg::TRIG_W-1:0] sat_trig(
		input logic signed [RND_W-1:0] v
	);
		logic signed [upi_pkg::TRIG_W-1:0] r;
		if (v > RND_W'(32767))
			r = 16'sh7FFF;
		else if (v < -RND_W'(32768))
			r = 16'sh8000;
		else
			r = v[upi_pkg::TRIG_W-1:0];
		return r;
	endfunction

	function automatic logic signed [Z_W-1:0] z_nx_f(
		input logic signed [Z_W-1:0] z,
		input logic signed [Z_W-1:0] t
	);
		return z[Z_W-1] ? z + t : z - t;
	endfunction

	// Widen heading to a 32-bit angle, fold second/third quadrant by a half turn
	assign a_full = {angle, {(32-upi_pkg::ANGLE_BITS){1'b0}}};
	assign fold   = a_full[31] ^ a_full[30];
	assign a_rot  = {a_full[31] ^ fold, a_full[30:0]};
	assign z_init = $signed({a_rot[31], a_rot});

	// One micro-rotation
	assign xs        = x_q >>> iter_q;
	assign ys        = y_q >>> iter_q;
	assign step_atan = $signed({1'b0, upi_pkg::atan_angle(upi_pkg::TAB_IDX_W'(iter_q))});
	assign x_nx      = z_q[Z_W-1] ? x_q + ys : x_q - ys;
	assign y_nx      = z_q[Z_W-1] ? y_q - xs : y_q + xs;
	assign last_iter = (iter_q == upi_pkg::ITER_W'(upi_pkg::CORDIC_STEPS - 1));

	// Undo the fold, round half up from Q2.30 to Q1.15
	assign xn    = neg_q ? -x_q : x_q;
	assign yn    = neg_q ? -y_q : y_q;
	assign x_rnd = (XY_W+1)'(xn) + (XY_W+1)'(1 << 14);
	assign y_rnd = (XY_W+1)'(yn) + (XY_W+1)'(1 << 14);

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= 1'b0;
			done_q  <= 1'b0;
			iter_q  <= '0;
		end else begin
			done_q  <= round_q;
			round_q <= busy_q && last_iter;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (last_iter)
					busy_q <= 1'b0;
			end
		end
	end

	// Datapath: load, rotate, round
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			x_q   <= upi_pkg::CORDIC_GAIN;
			y_q   <= '0;
			z_q   <= z_init;
			neg_q <= fold;
		end else if (busy_q) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx_f(z_q, step_atan);
		end
		if (round_q) begin
			cos_q <= sat_trig(x_rnd[XY_W:15]);
			sin_q <= sat_trig(y_rnd[XY_W:15]);
		end
	end

	assign done    = done_q;
	assign cos_val = cos_q;
	assign sin_val = sin_q;

endmodule

### tb/unicycle_pose_integrator_test.sv
// Self-checking testbench for the unicycle pose integrator: directed table, then random drive.
`timescale 1ns / 1ps

module unicycle_pose_integrator_test;

	localparam int ITEM_TARGET = 1400;
	localparam int CALM_TAIL = 150;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int ROTATIONS = 16;
	localparam longint TRIG_START = 652032874;
	localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

	// atan(2^-i) in 32-bit binary angle units
	localparam longint ARCTAN [ROTATIONS] = '{
		'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4,
		'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
		'h0028BE53, 'h00145F2E, 'h000A2F98, 'h000517CC,
		'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C
	};

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0]        hd;
		logic signed [15:0] spd;
		logic signed [20:0] rate;
	} pose_t;

	typedef struct packed {
		logic [15:0]        step;
		logic signed [15:0] spd;
		logic signed [20:0] rate;
		logic               known;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [15:0]        hd;
	} drive_row_t;

	// Directed commands; rows marked known carry the pose expected by inspection
	localparam int NUM_ROWS = 18;
	localparam drive_row_t DRIVE_ROWS [NUM_ROWS] = '{
		'{16'd6554,  16'sd0,     21'sd0,       1'b1, 32'sd65536, 32'sd65536, 16'd0},
		'{16'd0,     16'sh7FFF,  21'sh0FFFFF,  1'b1, 32'sd65536, 32'sd65536, 16'd0},
		'{16'd0,     16'sh8000,  21'sh100000,  1'b1, 32'sd65536, 32'sd65536, 16'd0},
		'{16'd32768, 16'sd256,   21'sd32768,   1'b0, 32'sd0, 32'sd0, 16'd0},
		'{16'd32768, 16'sd256,   21'sd32768,   1'b0, 32'sd0, 32'sd0, 16'd0},
		'{16'd32768, 16'sd256,   21'sd32768,   1'b0, 32'sd0, 32'sd0, 16'd0},
		'{16'd32768, 16'sd256,   21'sd32768,   1'b0, 32'sd0, 32'sd0, 16'd0},
		'{16'd32768, 16'sd256,   -21'sd2,      1'b0, 32'sd0, 32'sd0, 16'd0},
		'{16'd32768, 16'sd256,   21'sd1,       1'b0, 32'sd0, 32'sd0, 16'd0},
		'{16'd32768, -16'sd256,  21'sd16384,   1'b0, 32'sd0, 32'sd0, 16'd0},
		'{16'd65535, 16'sh7FFF,  21'sd0,       1'b0, 32'sd0, 32'sd0, 16'd0},
		'{16'd65535, 16'sh8000,  21'sh0FFFFF,  1'b0, 32'sd0, 32'sd0, 16'd0},
		'{16'd65535, 16'sd100,   21'sh100000,  1'b0, 32'sd0, 32'sd0, 16'd0},
		'{16'd1,     16'sh7FFF,  21'sh0FFFFF,  1'b0, 32'sd0, 32'sd0, 16'd0},
		'{16'd1,     16'sh8000,  21'sh100000,  1'b0, 32'sd0, 32'sd0, 16'd0},
		'{16'd1,     16'sd1,     21'sd1,       1'b0, 32'sd0, 32'sd0, 16'd0},
		'{16'd6554,  16'sd256,   -21'sd65536,  1'b0, 32'sd0, 32'sd0, 16'd0},
		'{16'd6554,  -16'sd1,    21'sd1000,    1'b0, 32'sd0, 32'sd0, 16'd0}
	};

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [15:0]        cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [15:0] forward_speed = '0;
	logic signed [20:0] turn_rate = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] pose_x;
	logic signed [31:0] pose_y;
	logic [15:0]        heading;
	logic signed [15:0] linear_speed_echo;
	logic signed [20:0] angular_speed_echo;

	// Predicted block state and configuration
	logic [15:0]        step_model = 16'd6554;
	logic [15:0]        head_model = 16'd0;
	logic signed [31:0] pos_x_model = 32'sd65536;
	logic signed [31:0] pos_y_model = 32'sd65536;

	pose_t pending_poses[$];
	int    commands_sent = 0;
	int    mismatch_count = 0;
	int    idle_cycles = 0;
	int    send_gap_odds = 0;
	int    ready_gap_odds = 0;

	unicycle_pose_integrator u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.forward_speed      (forward_speed),
		.turn_rate          (turn_rate),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.pose_x             (pose_x),
		.pose_y             (pose_y),
		.heading            (heading),
		.linear_speed_echo  (linear_speed_echo),
		.angular_speed_echo (angular_speed_echo)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Advance heading, rotate to cos/sin, step the saturating position; return the pose
	function automatic pose_t integrate_command(input logic signed [15:0] spd,
			input logic signed [20:0] rate);
		longint      inc;
		longint      x;
		longint      y;
		longint      z;
		longint      xs;
		longint      ys;
		longint      cos_q;
		longint      sin_q;
		logic [31:0] ang;
		logic        flip;
		pose_t       res;
		inc = (longint'(rate) * longint'(step_model) + 64'sd32768) >>> 16;
		head_model = head_model + inc[15:0];

		// fold the second and third quadrant onto the right half plane
		ang = {head_model, 16'h0000};
		flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
		if (flip) begin
			ang = ang + 32'h8000_0000;
		end
		z = longint'(signed'(ang));
		x = TRIG_START;
		y = 0;
		for (int i = 0; i < ROTATIONS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ARCTAN[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ARCTAN[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		cos_q = clamp((x + 64'sd16384) >>> 15, -32768, 32767);
		sin_q = clamp((y + 64'sd16384) >>> 15, -32768, 32767);

		// Q7.8 * Q0.16 * Q1.15 has 39 fraction bits; round to 16
		pos_x_model = 32'(clamp(longint'(pos_x_model) + ((longint'(spd) * longint'(step_model)
			* cos_q + 64'sd4194304) >>> 23), longint'(POS_MIN), longint'(POS_MAX)));
		pos_y_model = 32'(clamp(longint'(pos_y_model) + ((longint'(spd) * longint'(step_model)
			* sin_q + 64'sd4194304) >>> 23), longint'(POS_MIN), longint'(POS_MAX)));

		res.x = pos_x_model;
		res.y = pos_y_model;
		res.hd = head_model;
		res.spd = spd;
		res.rate = rate;
		return res;
	endfunction

	// Present one command, optionally after a gap, and hold it until accepted
	task automatic send_command(input logic signed [15:0] spd, input logic signed [20:0] rate);
		if (send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		forward_speed <= spd;
		turn_rate <= rate;
		do @(posedge clk); while (!in_ready);
		pending_poses.push_back(integrate_command(spd, rate));
		commands_sent++;
	endtask

	// Drain every pending pose, then write the time step while the block is idle
	task automatic set_time_step(input logic [15:0] dt);
		in_valid <= 1'b0;
		while (pending_poses.size() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= dt;
		@(posedge clk);
		cfg_we <= 1'b0;
		step_model = dt;
	endtask

	task automatic flag_mismatch(input string what, input longint want, input longint got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
		end
	endtask

	task automatic check_field(input string what, input longint want, input longint got);
		if (want != got) begin
			flag_mismatch(what, want, got);
		end
	endtask

	// Compare each pose transaction with the oldest prediction
	always @(posedge clk) begin : check_poses
		pose_t want;
		if (out_valid && out_ready) begin
			if (pending_poses.size() == 0) begin
				flag_mismatch("pose with no command pending, pose_x", 0, pose_x);
			end else begin
				want = pending_poses.pop_front();
				check_field("pose_x", want.x, pose_x);
				check_field("pose_y", want.y, pose_y);
				check_field("heading", want.hd, heading);
				check_field("linear_speed_echo", want.spd, linear_speed_echo);
				check_field("angular_speed_echo", want.rate, angular_speed_echo);
			end
		end
	end

	// Stall the result side in random bursts
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (ready_gap_odds != 0 && $urandom_range(1, ready_gap_odds) == 1) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Abort when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : drive_commands
		drive_row_t         row;
		pose_t              known_pose;
		logic [15:0]        dt_pick;
		logic [15:0]        corner_heading;
		logic signed [15:0] turn_need;
		logic signed [15:0] spd_pick;
		logic signed [20:0] rate_pick;
		int                 phase;
		int                 guard;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: reset pose, zero step, quadrant turns, wraps, field extremes
		for (int r = 0; r < NUM_ROWS; r++) begin
			row = DRIVE_ROWS[r];
			if (row.step != step_model) begin
				set_time_step(row.step);
			end
			send_command(row.spd, row.rate);
			if (row.known) begin
				known_pose = '{row.px, row.py, row.hd, row.spd, row.rate};
				pending_poses[pending_poses.size() - 1] = known_pose;
			end
		end

		// Random phases, each with its own time step and idling mix
		phase = 0;
		while (commands_sent < ITEM_TARGET) begin
			phase++;
			if (commands_sent >= ITEM_TARGET - CALM_TAIL) begin
				send_gap_odds = 0;
				ready_gap_odds = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: send_gap_odds = 0;
					1: send_gap_odds = 2;
					2: send_gap_odds = 5;
					default: send_gap_odds = 12;
				endcase
				case ($urandom_range(0, 3))
					0: ready_gap_odds = 0;
					1: ready_gap_odds = 2;
					2: ready_gap_odds = 5;
					default: ready_gap_odds = 12;
				endcase
			end

			if (phase == 3) begin
				// steer toward the nearest corner, run into both walls, then back off
				set_time_step(16'd65535);
				if (pos_x_model >= 0) begin
					corner_heading = (pos_y_model >= 0) ? 16'd8192 : 16'd57344;
				end else begin
					corner_heading = (pos_y_model >= 0) ? 16'd24576 : 16'd40960;
				end
				turn_need = corner_heading - head_model;
				send_command(16'sd0, turn_need);
				guard = 0;
				while (!((pos_x_model == POS_MAX || pos_x_model == POS_MIN)
						&& (pos_y_model == POS_MAX || pos_y_model == POS_MIN))
						&& guard < 420) begin
					send_command(16'sh7FFF, 21'sd0);
					guard++;
				end
				repeat (6) send_command(16'sh7FFF, 21'sd0);
				repeat (6) send_command(16'sh8000, 21'sd0);
			end else begin
				case ($urandom_range(0, 5))
					0: dt_pick = 16'd1;
					1: dt_pick = 16'd65535;
					2: dt_pick = 16'd0;
					3: dt_pick = 16'd6554;
					default: dt_pick = 16'($urandom_range(1, 65535));
				endcase
				set_time_step(dt_pick);
				repeat ($urandom_range(40, 120)) begin
					case ($urandom_range(0, 9))
						0: spd_pick = 16'sh7FFF;
						1: spd_pick = 16'sh8000;
						2: spd_pick = 16'sd0;
						default: spd_pick = 16'($urandom);
					endcase
					case ($urandom_range(0, 9))
						0: rate_pick = 21'sh0FFFFF;
						1: rate_pick = 21'sh100000;
						2: rate_pick = 21'sd0;
						3, 4: rate_pick = 21'($urandom_range(0, 8191)) - 21'sd4096;
						default: rate_pick = 21'($urandom);
					endcase
					send_command(spd_pick, rate_pick);
				end
			end
		end

		// Let the last poses drain, then settle
		in_valid <= 1'b0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_poses.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
